FILE: rtl/matrix_stack_mvp_unit_defines.svh
// Assertion macros shared by the matrix unit RTL files.
`ifndef MATRIX_STACK_MVP_UNIT_DEFINES_SVH
`define MATRIX_STACK_MVP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define MSM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MSM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MSM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/msm_pkg.sv
// Package with types, codes and constants of the matrix unit.
`default_nettype none
package msm_pkg;
   localparam int DefStackDepth = 32;
   localparam int FracBits = 16;
   localparam logic [31:0] OneFixed = 32'h0001_0000;

   typedef enum logic [2:0] {
      OP_STAGE = 3'd0, OP_APPLY = 3'd1, OP_POP = 3'd2,
      OP_FORCE = 3'd3, OP_INSERT = 3'd4, OP_READ = 3'd5
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic               push_flag;
      logic               load_flag;
      logic               projection_flag;
      logic [15:0]        pop_count;
      logic [5:0]         insert_offset;
      logic [31:0]        insert_word;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [3:0]         result_index;
      logic               last;
      logic               status;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_MUL_WB, ST_COPY, ST_COPY_WB, ST_INS_RD, ST_INS_WB,
      ST_RD_RD, ST_RD_OUT, ST_STATUS, ST_DONE
   } state_type;

   // Matrix selectors for the datapath.
   typedef enum logic [2:0] {
      M_STAGE, M_PROJ, M_TOP, M_COMB, M_TMP
   } msel_type;

   typedef struct packed {
      logic     clear_acc;
      logic     mac;
      logic     tmp_write;
      msel_type a_sel;
      msel_type b_sel;
      msel_type rd_sel;
      msel_type wr_sel;
      logic     wr_en;
      logic     wr_from_tmp;
      logic     wr_from_stage;
      logic     wr_from_patch;
      logic     stack_up;
      logic [3:0] row;
      logic [3:0] col;
      logic [1:0] k;
   } dp_cmd_type;

   function automatic logic [31:0] ident_elem(input logic [3:0] idx);
      return (idx == 4'd0 || idx == 4'd5 || idx == 4'd10 || idx == 4'd15) ? OneFixed : 32'd0;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/msm_if.sv
// Valid/ready channel interface.
`default_nettype none
interface msm_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/msm_datapath.sv
// Datapath: matrices, stack memory, shared multiply-accumulate unit.
`default_nettype none
`include "matrix_stack_mvp_unit_defines.svh"
module msm_datapath import msm_pkg::*; #(
   parameter int STACK_DEPTH = DefStackDepth,
   parameter int TopWidth = $clog2(STACK_DEPTH)
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire dp_cmd_type   cmd,
   input  wire logic [TopWidth-1:0] top_level,
   input  wire logic         stage_we,
   input  wire logic [3:0]   stage_idx,
   input  wire logic [31:0]  stage_val,
   input  wire logic [15:0]  patch_half,
   input  wire logic         patch_frac,
   output logic [31:0]       rd_data
);
   logic [31:0] stage_ff [16];
   logic [31:0] proj_ff [16];
   logic [15:0] proj_valid_ff;
   logic [31:0] comb_ff [16];
   logic [31:0] tmp_ff [16];
   logic [31:0] stack_mem [STACK_DEPTH*16];
   logic [15:0] stack_valid_ff;
   logic [31:0] stack_q_ff;
   logic [3:0]  stack_qidx_ff;
   logic        stack_qv_ff;
   logic [63:0] acc_ff;
   logic [63:0] prod_ff;
   logic        prod_v_ff;
   logic [31:0] a_val, b_val, top_val, wr_val, rd_q;
   logic [3:0]  a_idx, b_idx, rd_idx, top_idx;
   logic [TopWidth-1:0] rd_level, wr_level;

   assign a_idx = {cmd.row[1:0], cmd.k};
   assign b_idx = {cmd.k, cmd.col[1:0]};
   assign rd_idx = {cmd.row[1:0], cmd.col[1:0]};
   assign top_idx = (cmd.a_sel == M_TOP) ? a_idx : (cmd.b_sel == M_TOP) ? b_idx : rd_idx;
   assign rd_level = top_level;
   assign wr_level = cmd.stack_up ? TopWidth'(top_level + 1'b1) : top_level;

   // Stack memory read is registered; level 0 elements read identity until written.
   always_ff @(posedge clock) begin
      stack_q_ff <= stack_mem[{rd_level, top_idx}];
      stack_qidx_ff <= top_idx;
      stack_qv_ff <= (rd_level != '0) || stack_valid_ff[top_idx];
      if (cmd.wr_en && cmd.wr_sel == M_TOP)
         stack_mem[{wr_level, rd_idx}] <= wr_val;
   end
   assign top_val = stack_qv_ff ? stack_q_ff : ident_elem(stack_qidx_ff);

   always_comb begin
      case (cmd.a_sel)
         M_STAGE: a_val = stage_ff[a_idx];
         M_TOP:   a_val = top_val;
         default: a_val = 32'd0;
      endcase
      case (cmd.b_sel)
         M_PROJ:  b_val = proj_valid_ff[b_idx] ? proj_ff[b_idx] : ident_elem(b_idx);
         M_TOP:   b_val = top_val;
         default: b_val = 32'd0;
      endcase
      case (cmd.rd_sel)
         M_TOP:   rd_q = top_val;
         M_PROJ:  rd_q = proj_valid_ff[rd_idx] ? proj_ff[rd_idx] : ident_elem(rd_idx);
         M_COMB:  rd_q = comb_ff[rd_idx];
         default: rd_q = tmp_ff[rd_idx];
      endcase
      if (cmd.wr_from_tmp)        wr_val = tmp_ff[rd_idx];
      else if (cmd.wr_from_stage) wr_val = stage_ff[rd_idx];
      else if (cmd.wr_from_patch)
         wr_val = patch_frac ? {comb_ff[rd_idx][31:16], patch_half}
                             : {patch_half, comb_ff[rd_idx][15:0]};
      else                        wr_val = top_val;
   end
   assign rd_data = rd_q;

   always_ff @(posedge clock) begin
      prod_v_ff <= cmd.mac;
      prod_ff <= 64'($signed(a_val)) * 64'($signed(b_val));
      if (cmd.clear_acc) acc_ff <= 64'd0;
      else if (prod_v_ff) acc_ff <= acc_ff + prod_ff;
      if (cmd.tmp_write) tmp_ff[rd_idx] <= acc_ff[FracBits+31:FracBits];
      if (stage_we) stage_ff[stage_idx] <= stage_val;
      if (cmd.wr_en && cmd.wr_sel == M_PROJ) proj_ff[rd_idx] <= wr_val;
      if (cmd.wr_en && cmd.wr_sel == M_COMB) comb_ff[rd_idx] <= wr_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         proj_valid_ff <= '0;
         stack_valid_ff <= '0;
      end else if (cmd.wr_en) begin
         if (cmd.wr_sel == M_PROJ) proj_valid_ff[rd_idx] <= 1'b1;
         if (cmd.wr_sel == M_TOP && wr_level == '0) stack_valid_ff[rd_idx] <= 1'b1;
      end
   end

   `MSM_ASSERT_NEXT(a_prod_follows, clock, reset, cmd.mac, prod_v_ff)
   `MSM_ASSERT_IMPL(a_no_clear_mac, clock, reset, cmd.clear_acc, !cmd.mac)
   `MSM_ASSERT_IMPL(a_one_src, clock, reset, cmd.wr_en,
      $onehot0({cmd.wr_from_tmp, cmd.wr_from_stage, cmd.wr_from_patch}))
endmodule
`default_nettype wire

FILE: rtl/msm_ctrl.sv
// Controller state machine sequencing multiplies, copies and reads.
`default_nettype none
`include "matrix_stack_mvp_unit_defines.svh"
module msm_ctrl import msm_pkg::*; #(
   parameter int STACK_DEPTH = DefStackDepth,
   parameter int TopWidth = $clog2(STACK_DEPTH)
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [2:0] op,
   input  wire logic       push_f,
   input  wire logic       load_f,
   input  wire logic       proj_f,
   input  wire logic [15:0] pop_count,
   input  wire logic [5:0] ins_off,
   input  wire logic [31:0] ins_word,
   output logic            stage_we,
   output dp_cmd_type      cmd,
   output logic [TopWidth-1:0] top_level,
   output logic [15:0]     patch_half,
   output logic            patch_frac,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [3:0]      rsp_idx,
   output logic            rsp_last,
   output logic            rsp_status,
   output logic            rsp_zero
);
   state_type state_ff, state_in;
   logic [TopWidth-1:0] top_ff, top_in;
   logic stale_ff, stale_in;
   logic [3:0] idx_ff, idx_in;
   logic [1:0] k_ff, k_in;
   logic [1:0] phase_ff, phase_in;
   logic mul_comb_ff, mul_comb_in;
   logic load_ff, projm_ff, frac_ff, bad_ff;
   logic [31:0] word_ff;
   logic [3:0] base_ff;
   op_type cur_ff;
   logic [TopWidth:0] top_wide;
   logic [15:0] removed;
   logic accept;

   assign accept = req_valid && req_ready;
   assign top_wide = {1'b0, top_ff};
   assign removed = (pop_count < 16'(top_ff)) ? pop_count : 16'(top_ff);
   assign top_level = top_ff;
   assign patch_frac = frac_ff;
   assign patch_half = (idx_ff == base_ff) ? word_ff[31:16] : word_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         top_ff <= '0;
         stale_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         top_ff <= top_in;
         stale_ff <= stale_in;
      end
      idx_ff <= idx_in; k_ff <= k_in; phase_ff <= phase_in; mul_comb_ff <= mul_comb_in;
      if (accept) begin
         cur_ff <= op_type'(op);
         load_ff <= load_f; projm_ff <= proj_f;
         frac_ff <= ins_off[5]; bad_ff <= ins_off[1:0] != 2'd0;
         word_ff <= ins_word; base_ff <= {ins_off[4:2], 1'b0};
      end
   end

   always_comb begin
      state_in = state_ff; top_in = top_ff; stale_in = stale_ff;
      idx_in = idx_ff; k_in = k_ff; phase_in = phase_ff; mul_comb_in = mul_comb_ff;
      req_ready = 1'b0; stage_we = 1'b0; cmd = '0;
      cmd.row = {2'b0, idx_ff[3:2]}; cmd.col = {2'b0, idx_ff[1:0]}; cmd.k = k_ff;
      rsp_valid = 1'b0; rsp_idx = idx_ff; rsp_last = 1'b0; rsp_status = 1'b0; rsp_zero = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in = 4'd0; k_in = 2'd0; phase_in = 2'd0; cmd.clear_acc = 1'b1;
               case (op)
                  OP_STAGE: stage_we = 1'b1;
                  OP_APPLY: begin
                     stale_in = 1'b1;
                     mul_comb_in = 1'b0;
                     if (!proj_f && push_f && (top_wide + 1'b1 < (TopWidth+1)'(STACK_DEPTH)))
                        state_in = ST_COPY;
                     else
                        state_in = load_f ? ST_COPY_WB : ST_MUL;
                  end
                  OP_POP: if (removed != 16'd0) begin
                     top_in = top_ff - TopWidth'(removed);
                     stale_in = 1'b1;
                  end
                  OP_FORCE: begin
                     state_in = ST_COPY_WB; stale_in = 1'b0; mul_comb_in = 1'b0;
                  end
                  OP_INSERT: begin
                     if (ins_off[1:0] != 2'd0) state_in = ST_STATUS;
                     else if (stale_ff) begin state_in = ST_MUL; mul_comb_in = 1'b1; end
                     else state_in = ST_INS_RD;
                  end
                  OP_READ: begin
                     if (stale_ff) begin state_in = ST_MUL; mul_comb_in = 1'b1; end
                     else state_in = ST_RD_RD;
                  end
                  default: ;
               endcase
            end
         end
         // phase 0: issue stack read, 1: mac with registered data; drain is in ST_MUL_WB
         ST_MUL: begin
            if (mul_comb_ff) begin
               cmd.a_sel = M_TOP; cmd.b_sel = M_PROJ;
            end else begin
               cmd.a_sel = M_STAGE; cmd.b_sel = projm_ff ? M_PROJ : M_TOP;
            end
            cmd.mac = (phase_ff == 2'd1);
            if (cmd.mac && cmd.a_sel == M_STAGE && projm_ff) cmd.mac = 1'b1;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd1) begin
               phase_in = 2'd0;
               k_in = k_ff + 2'd1;
               if (k_ff == 2'd3) state_in = ST_MUL_WB;
            end
         end
         ST_MUL_WB: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd1) begin
               cmd.tmp_write = 1'b1;
               cmd.clear_acc = 1'b1;
               phase_in = 2'd0; k_in = 2'd0;
               idx_in = idx_ff + 4'd1;
               state_in = (idx_ff == 4'd15) ? ST_COPY_WB : ST_MUL;
            end
         end
         ST_COPY: begin
            cmd.rd_sel = M_TOP;
            phase_in = 2'd1;
            state_in = ST_COPY;
            if (phase_ff == 2'd1) begin
               cmd.wr_en = 1'b1; cmd.wr_sel = M_TOP; cmd.stack_up = 1'b1;
               phase_in = 2'd0; idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd15) begin
                  top_in = top_ff + 1'b1;
                  state_in = load_ff ? ST_COPY_WB : ST_MUL;
               end
            end
         end
         ST_COPY_WB: begin
            // Write back product, staging or forced matrix.
            cmd.wr_en = 1'b1;
            if (cur_ff == OP_FORCE) begin
               cmd.wr_sel = M_COMB; cmd.wr_from_stage = 1'b1;
            end else if (mul_comb_ff) begin
               cmd.wr_sel = M_COMB; cmd.wr_from_tmp = 1'b1;
            end else begin
               cmd.wr_sel = projm_ff ? M_PROJ : M_TOP;
               if (load_ff) cmd.wr_from_stage = 1'b1; else cmd.wr_from_tmp = 1'b1;
            end
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd15) begin
               idx_in = 4'd0;
               if (mul_comb_ff) begin
                  stale_in = 1'b0;
                  state_in = (cur_ff == OP_READ) ? ST_RD_RD : ST_INS_RD;
               end else state_in = ST_IDLE;
            end
         end
         ST_INS_RD: begin
            idx_in = base_ff; state_in = ST_INS_WB;
         end
         ST_INS_WB: begin
            cmd.wr_en = 1'b1; cmd.wr_sel = M_COMB; cmd.wr_from_patch = 1'b1;
            idx_in = idx_ff + 4'd1;
            if (idx_ff != base_ff) state_in = ST_STATUS;
         end
         ST_STATUS: begin
            rsp_valid = 1'b1; rsp_idx = 4'd0; rsp_last = 1'b1;
            rsp_status = bad_ff; rsp_zero = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         ST_RD_RD: begin
            cmd.rd_sel = M_COMB;
            rsp_valid = 1'b1; rsp_last = (idx_ff == 4'd15);
            if (rsp_ready) begin
               idx_in = idx_ff + 4'd1;
               if (idx_ff == 4'd15) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `MSM_ASSERT_IMPL(a_ready_idle, clock, reset, req_ready, state_ff == ST_IDLE)
   `MSM_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid, !req_ready)
   `MSM_ASSERT_NEXT(a_force_fresh, clock, reset, accept && op == OP_FORCE, !stale_ff)
endmodule
`default_nettype wire

FILE: rtl/matrix_stack_mvp_unit.sv
// Top level of the s15.16 matrix stack unit.
//  channel | dir | payload
//  req     | in  | operation, element, flags, pop count, insert fields
//  rsp     | out | result_value, result_index, last, status
// One item at a time. Stage, pop and no-op stay in idle; force writes the staging
// matrix into the combined matrix. A matrix multiply is 64 MAC steps on one
// multiplier plus drain and write back; a push adds a copy of the top matrix.
// Read emits 16 beats, one per cycle that rsp_ready is high.
// Synchronous reset; no clearing pass, identity defaults come from valid bits.
`default_nettype none
module matrix_stack_mvp_unit import msm_pkg::*; #(
   parameter int STACK_DEPTH = DefStackDepth
) (
   input wire logic clock,
   input wire logic reset,
   msm_if.sink   req_bus,
   msm_if.source rsp_bus
);
   localparam int TopWidth = $clog2(STACK_DEPTH);
   dp_cmd_type cmd;
   logic stage_we, patch_frac, rsp_zero, rsp_last, rsp_status;
   logic [15:0] patch_half;
   logic [3:0] rsp_idx;
   logic [31:0] rd_data;
   logic [TopWidth-1:0] top_level;

   msm_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
      .clock, .reset,
      .req_valid(req_bus.valid), .req_ready(req_bus.ready),
      .op(req_bus.payload.operation), .push_f(req_bus.payload.push_flag),
      .load_f(req_bus.payload.load_flag), .proj_f(req_bus.payload.projection_flag),
      .pop_count(req_bus.payload.pop_count), .ins_off(req_bus.payload.insert_offset),
      .ins_word(req_bus.payload.insert_word),
      .stage_we, .cmd, .top_level, .patch_half, .patch_frac,
      .rsp_valid(rsp_bus.valid), .rsp_ready(rsp_bus.ready), .rsp_idx, .rsp_last,
      .rsp_status, .rsp_zero);

   msm_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .cmd, .top_level, .stage_we,
      .stage_idx(req_bus.payload.element_index), .stage_val(req_bus.payload.element_value),
      .patch_half, .patch_frac, .rd_data);

   assign rsp_bus.payload.result_value = rsp_zero ? 32'sd0 : $signed(rd_data);
   assign rsp_bus.payload.result_index = rsp_idx;
   assign rsp_bus.payload.last = rsp_last;
   assign rsp_bus.payload.status = rsp_status;
endmodule
`default_nettype wire
